/* rtl/swgc_pkg.sv */
`default_nettype none

package swgc_pkg;

  localparam int CHAR_W   = 8;
  localparam int POS_W    = 32;
  localparam int CNT_OUT_W = 13;
  localparam int BIN_W    = 16;
  localparam int WL_W     = 13;
  localparam int REG_W    = 16;
  localparam int REG_IDX_W = 2;
  localparam int LEN_MIN  = 8;
  localparam int QUAL_MARGIN = 7;
  localparam int DATA_IN_W  = 8;
  localparam int DATA_OUT_W = 96;

  localparam logic [CHAR_W-1:0] CHAR_G = 8'h47;
  localparam logic [CHAR_W-1:0] CHAR_C = 8'h43;
  localparam logic [CHAR_W-1:0] CHAR_N = 8'h4E;

  localparam logic [WL_W-1:0]  WL_RESET = 13'd500;
  localparam logic [REG_W-1:0] BW_RESET = 16'd6554;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_WINDOW_LENGTH = 2'd0,
    REG_GC_BIN_WIDTH  = 2'd1,
    REG_N_BIN_WIDTH   = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    CLS_OTHER = 2'd0,
    CLS_GC    = 2'd1,
    CLS_N     = 2'd2
  } cls_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPDATE,
    S_GC_START,
    S_GC_WAIT,
    S_N_START,
    S_N_WAIT,
    S_OUT
  } state_e;

  typedef struct packed {
    logic accept;
    logic update;
    logic div_start;
    logic div_sel;
    logic store_gc;
    logic store_n;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic emit;
    logic div_done;
    logic out_free;
  } status_t;

  function automatic cls_e classify(input logic [CHAR_W-1:0] c);
    cls_e res;
    if (c == CHAR_G || c == CHAR_C) begin
      res = CLS_GC;
    end else if (c == CHAR_N) begin
      res = CLS_N;
    end else begin
      res = CLS_OTHER;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

/* rtl/swgc_div.sv */
`default_nettype none

module swgc_div import swgc_pkg::*; #(
  parameter int NUM_W = 29,
  parameter int DEN_W = 29
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic                  done_o,
  output logic [BIN_W-1:0]      quo_o
);

  localparam int CMP_W = (DEN_W + BIN_W > NUM_W) ? DEN_W + BIN_W : NUM_W;
  localparam int STEPS = BIN_W + 1;
  localparam int CNT_W = $clog2(STEPS);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [NUM_W-1:0] rem_q;
  logic [CMP_W-1:0] dsh_q;
  logic [BIN_W-1:0] quo_q;
  logic             ovf_q;

  logic             ge;
  logic [CMP_W-1:0] diff;
  logic             last;

  assign ge   = CMP_W'(rem_q) >= dsh_q;
  assign diff = CMP_W'(rem_q) - dsh_q;
  assign last = cnt_q == CNT_W'(STEPS - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      done_q <= last;
      cnt_q  <= cnt_q + CNT_W'(1);
      if (last) begin
        busy_q <= 1'b0;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // The first step only checks whether the quotient fits in BIN_W bits;
  // the remaining steps produce one quotient bit each, top bit first.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i;
      dsh_q <= CMP_W'(den_i) << BIN_W;
      quo_q <= '0;
      ovf_q <= 1'b0;
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        ovf_q <= ge;
      end else begin
        if (ge) begin
          rem_q <= diff[NUM_W-1:0];
        end
        quo_q <= {quo_q[BIN_W-2:0], ge};
      end
      dsh_q <= dsh_q >> 1;
    end
  end

  assign done_o = done_q;
  assign quo_o  = ovf_q ? '1 : quo_q;

endmodule

`default_nettype wire

/* rtl/swgc_dp.sv */
`default_nettype none

module swgc_dp import swgc_pkg::*; #(
  parameter int MAX_WINDOW    = 4096,
  parameter int BIN_FRAC_BITS = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [REG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [REG_W-1:0]     cfg_data_i,
  input  wire logic [CHAR_W-1:0]    base_char_i,
  input  wire logic                 first_i,
  input  wire cmd_t                 cmd_i,
  output status_t                   sts_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [POS_W-1:0]          window_start_o,
  output logic [CNT_OUT_W-1:0]      gc_total_o,
  output logic [CNT_OUT_W-1:0]      n_total_o,
  output logic                      qualified_o,
  output logic [BIN_W-1:0]          gc_bin_o,
  output logic [BIN_W-1:0]          n_bin_o
);

  localparam int LEN_W = $clog2(MAX_WINDOW + 1);
  localparam int PTR_W = $clog2(MAX_WINDOW);
  localparam int IDX_W = LEN_W + 1;
  localparam int NUM_W = LEN_W + BIN_FRAC_BITS;
  localparam int DEN_W = LEN_W + REG_W;

  // Configuration registers.
  logic [WL_W-1:0]  window_length_q;
  logic [REG_W-1:0] gc_bin_width_q;
  logic [REG_W-1:0] n_bin_width_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_length_q <= WL_RESET;
      gc_bin_width_q  <= BW_RESET;
      n_bin_width_q   <= BW_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_WINDOW_LENGTH: window_length_q <= cfg_data_i[WL_W-1:0];
        REG_GC_BIN_WIDTH:  gc_bin_width_q  <= cfg_data_i;
        REG_N_BIN_WIDTH:   n_bin_width_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic             restart_cfg;
  logic [31:0]      wl_ext;
  logic [LEN_W-1:0] len_c;

  assign restart_cfg = cfg_we_i && (cfg_idx_i == REG_WINDOW_LENGTH);
  assign wl_ext      = 32'(window_length_q);

  always_comb begin
    if (wl_ext < LEN_MIN) begin
      len_c = LEN_W'(LEN_MIN);
    end else if (wl_ext > MAX_WINDOW) begin
      len_c = LEN_W'(MAX_WINDOW);
    end else begin
      len_c = LEN_W'(wl_ext);
    end
  end

  // Window state.
  logic [LEN_W-1:0] gc_q, n_q, fill_q;
  logic [POS_W-1:0] start_q;
  logic [PTR_W-1:0] wr_q;
  cls_e             cls_q;
  cls_e             old_q;
  cls_e             delay_mem [MAX_WINDOW];

  cls_e             cls_c;
  logic [PTR_W-1:0] wr_eff;
  logic [LEN_W-1:0] wr_plus;
  logic [PTR_W-1:0] wr_nxt;
  logic [IDX_W-1:0] wr_ext, len_ext, old_sum;
  logic [PTR_W-1:0] old_idx;

  assign cls_c   = classify(base_char_i);
  assign wr_eff  = first_i ? '0 : wr_q;
  assign wr_plus = LEN_W'(wr_eff) + LEN_W'(1);
  assign wr_nxt  = (wr_plus == LEN_W'(MAX_WINDOW)) ? '0 : wr_plus[PTR_W-1:0];

  // Entry that leaves the window: len places behind the write pointer.
  assign wr_ext  = IDX_W'(wr_q);
  assign len_ext = IDX_W'(len_c);
  assign old_sum = (wr_ext >= len_ext) ? wr_ext - len_ext
                                       : wr_ext + IDX_W'(MAX_WINDOW) - len_ext;
  assign old_idx = old_sum[PTR_W-1:0];

  // The read sees the entry before this cycle's write, which matters when
  // the window spans the whole line.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      delay_mem[wr_eff] <= cls_c;
      old_q             <= delay_mem[old_idx];
      cls_q             <= cls_c;
    end
  end

  logic             drop;
  logic [LEN_W-1:0] gc_d, n_d, fill_d;
  logic [POS_W-1:0] start_d;

  assign drop    = fill_q >= len_c;
  assign gc_d    = gc_q - LEN_W'(drop && (old_q == CLS_GC)) + LEN_W'(cls_q == CLS_GC);
  assign n_d     = n_q - LEN_W'(drop && (old_q == CLS_N)) + LEN_W'(cls_q == CLS_N);
  assign fill_d  = drop ? fill_q : fill_q + LEN_W'(1);
  assign start_d = (drop && (start_q != '1)) ? start_q + POS_W'(1) : start_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gc_q    <= '0;
      n_q     <= '0;
      fill_q  <= '0;
      start_q <= '0;
      wr_q    <= '0;
    end else if (restart_cfg) begin
      gc_q    <= '0;
      n_q     <= '0;
      fill_q  <= '0;
      start_q <= '0;
      wr_q    <= '0;
    end else if (cmd_i.accept) begin
      if (first_i) begin
        gc_q    <= '0;
        n_q     <= '0;
        fill_q  <= '0;
        start_q <= '0;
      end
      wr_q <= wr_nxt;
    end else if (cmd_i.update) begin
      gc_q    <= gc_d;
      n_q     <= n_d;
      fill_q  <= fill_d;
      start_q <= start_d;
    end
  end

  // Operand selection for the shared divider.
  logic [LEN_W-1:0] nonn;
  logic [LEN_W-1:0] mul_a;
  logic [REG_W-1:0] mul_b;
  logic [DEN_W-1:0] den;
  logic [NUM_W-1:0] num;
  logic             div_done;
  logic [BIN_W-1:0] quo;

  assign nonn  = len_c - n_q;
  assign mul_a = cmd_i.div_sel ? len_c : nonn;
  assign mul_b = cmd_i.div_sel ? n_bin_width_q : gc_bin_width_q;
  assign den   = DEN_W'(mul_a) * DEN_W'(mul_b);
  assign num   = cmd_i.div_sel ? {n_q, {BIN_FRAC_BITS{1'b0}}}
                               : {gc_q, {BIN_FRAC_BITS{1'b0}}};

  swgc_div #(
    .NUM_W(NUM_W),
    .DEN_W(DEN_W)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.div_start),
    .num_i  (num),
    .den_i  (den),
    .done_o (div_done),
    .quo_o  (quo)
  );

  logic [BIN_W-1:0] gc_bin_q, n_bin_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.store_gc) begin
      gc_bin_q <= (nonn == '0) ? '0 : quo;
    end
    if (cmd_i.store_n) begin
      if (n_q == '0) begin
        n_bin_q <= '0;
      end else begin
        n_bin_q <= (quo == '1) ? quo : quo + BIN_W'(1);
      end
    end
  end

  // Output register.
  logic                 out_valid_q;
  logic [POS_W-1:0]     out_start_q;
  logic [CNT_OUT_W-1:0] out_gc_q, out_n_q;
  logic                 out_qual_q;
  logic [BIN_W-1:0]     out_gc_bin_q, out_n_bin_q;
  logic [31:0]          gc_wide, n_wide;
  logic                 qual_c;

  assign gc_wide = 32'(gc_q);
  assign n_wide  = 32'(n_q);
  assign qual_c  = (IDX_W'(n_q) + IDX_W'(QUAL_MARGIN)) < IDX_W'(len_c);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_start_q  <= start_q;
      out_gc_q     <= gc_wide[CNT_OUT_W-1:0];
      out_n_q      <= n_wide[CNT_OUT_W-1:0];
      out_qual_q   <= qual_c;
      out_gc_bin_q <= gc_bin_q;
      out_n_bin_q  <= n_bin_q;
    end
  end

  assign sts_o.emit     = (IDX_W'(fill_q) + IDX_W'(1)) >= IDX_W'(len_c);
  assign sts_o.div_done = div_done;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign window_start_o = out_start_q;
  assign gc_total_o     = out_gc_q;
  assign n_total_o      = out_n_q;
  assign qualified_o    = out_qual_q;
  assign gc_bin_o       = out_gc_bin_q;
  assign n_bin_o        = out_n_bin_q;

endmodule

`default_nettype wire

/* rtl/swgc_ctrl.sv */
`default_nettype none

module swgc_ctrl import swgc_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire status_t sts_i,
  output cmd_t         cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_UPDATE;
      end
      S_UPDATE: begin
        state_d = sts_i.emit ? S_GC_START : S_IDLE;
      end
      S_GC_START: state_d = S_GC_WAIT;
      S_GC_WAIT: begin
        if (sts_i.div_done) state_d = S_N_START;
      end
      S_N_START: state_d = S_N_WAIT;
      S_N_WAIT: begin
        if (sts_i.div_done) state_d = S_OUT;
      end
      S_OUT: begin
        if (sts_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      S_UPDATE: cmd_o.update = 1'b1;
      S_GC_START: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = 1'b0;
      end
      S_GC_WAIT: begin
        cmd_o.div_sel  = 1'b0;
        cmd_o.store_gc = sts_i.div_done;
      end
      S_N_START: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = 1'b1;
      end
      S_N_WAIT: begin
        cmd_o.div_sel = 1'b1;
        cmd_o.store_n = sts_i.div_done;
      end
      S_OUT: cmd_o.load_out = sts_i.out_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/sliding_window_gc_n_binner.sv */
// A base that completes a window goes through the count update, a GC bin division, an
// N bin division and the output load, which waits for a free output register, before
// m_axis_tvalid rises; other bases only update the counts. No new base is taken until the
// last is through, and the two 17-step bin divisions share the single divider in turn.
// Reset clears counts, position, write pointer and handshakes; the delay line is not
// cleared, since no entry is read before it has been written after a restart.
`default_nettype none

module sliding_window_gc_n_binner import swgc_pkg::*; #(
  parameter int MAX_WINDOW    = 4096,
  parameter int BIN_FRAC_BITS = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [REG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [REG_W-1:0]      cfg_data_i,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [DATA_IN_W-1:0]  s_axis_tdata,  // base_char[7:0]
  input  wire logic                  s_axis_tuser,  // first_of_sequence
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // window_start[31:0], gc_total[44:32], n_total[57:45], qualified[58],
  // gc_bin[74:59], n_bin[90:75], zero fill[95:91]
  output logic [DATA_OUT_W-1:0]      m_axis_tdata
);

  cmd_t    cmd;
  status_t sts;

  logic [POS_W-1:0]     window_start;
  logic [CNT_OUT_W-1:0] gc_total, n_total;
  logic                 qualified;
  logic [BIN_W-1:0]     gc_bin, n_bin;

  swgc_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  swgc_dp #(
    .MAX_WINDOW   (MAX_WINDOW),
    .BIN_FRAC_BITS(BIN_FRAC_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .base_char_i   (s_axis_tdata[CHAR_W-1:0]),
    .first_i       (s_axis_tuser),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .window_start_o(window_start),
    .gc_total_o    (gc_total),
    .n_total_o     (n_total),
    .qualified_o   (qualified),
    .gc_bin_o      (gc_bin),
    .n_bin_o       (n_bin)
  );

  assign m_axis_tdata = {5'b0, n_bin, gc_bin, qualified, n_total, gc_total, window_start};

  // Items are handled one at a time: an accepted base blocks the next one.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while a base is still in progress");

  // Both counts together never exceed MAX_WINDOW.
  a_counts_fit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (32'(gc_total) + 32'(n_total) <= 32'(MAX_WINDOW)))
    else $error("GC and N counts exceed the window length");

  // An N bin of zero is reserved for windows without any N base.
  a_n_bin_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (n_bin == '0)) |-> (n_total == '0))
    else $error("zero N bin for a window that holds N bases");

endmodule

`default_nettype wire
